// ----- rtl/core/cdq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the circular deque core: depth, widths, command and status codes,
// the structs passed between the control and the top level, and index helpers.
// No dependencies.
package cdq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic       pop_ok;
      status_type status;
      logic       is_empty;
      logic       is_full;
   } rsp_info_type;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + IDX_W'(1);
      end
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == '0) begin
         res = IDX_W'(DEPTH - 1);
      end else begin
         res = idx - IDX_W'(1);
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/cdq_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module cdq_ram #(
   parameter int DEPTH_P = 16,
   parameter int WIDTH_P = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] wr_addr,
   input  logic [WIDTH_P-1:0]                         wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] rd_addr,
   output logic [WIDTH_P-1:0]                         rd_data
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cdq_ctrl.sv -----
`timescale 1ns / 1ps
// Deque control: front and back indices, occupancy count, memory request and
// result status for each command. Depends on cdq_pkg.
module cdq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  cdq_pkg::cmd_type           command,
   input  logic [cdq_pkg::VAL_W-1:0]  value,
   output cdq_pkg::mem_req_type       mem_req,
   output cdq_pkg::rsp_info_type      info
);
   import cdq_pkg::*;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             is_push, empty_now, full_now;

   always_comb begin
      is_push   = (command == CMD_PUSH_FRONT) || (command == CMD_PUSH_BACK);
      empty_now = (count_ff == '0);
      full_now  = (count_ff == CNT_W'(DEPTH));
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      mem_req   = '0;
      mem_req.wr_data = value;
      info.pop_ok = 1'b0;
      info.status = ST_OK;
      if (is_push) begin
         if (full_now) begin
            info.status = ST_FULL;
         end else begin
            if (empty_now) begin
               tail_in = head_ff;
               mem_req.wr_addr = head_ff;
            end else if (command == CMD_PUSH_FRONT) begin
               head_in = idx_prev(head_ff);
               mem_req.wr_addr = head_in;
            end else begin
               tail_in = idx_next(tail_ff);
               mem_req.wr_addr = tail_in;
            end
            count_in = count_ff + CNT_W'(1);
            mem_req.wr_en = accept;
         end
      end else begin
         if (empty_now) begin
            info.status = ST_EMPTY;
         end else begin
            info.pop_ok = 1'b1;
            count_in = count_ff - CNT_W'(1);
            mem_req.rd_en = accept;
            if (command == CMD_POP_FRONT) begin
               mem_req.rd_addr = head_ff;
               if (count_ff != CNT_W'(1)) begin
                  head_in = idx_next(head_ff);
               end
            end else begin
               mem_req.rd_addr = tail_ff;
               if (count_ff != CNT_W'(1)) begin
                  tail_in = idx_prev(tail_ff);
               end
            end
         end
      end
      info.is_empty = (count_in == '0);
      info.is_full  = (count_in == CNT_W'(DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/circular_deque_core.sv -----
`timescale 1ns / 1ps
// Top level of the circular deque: stream handshakes, entry RAM, control and
// the result register. Depends on cdq_pkg, cdq_ram and cdq_ctrl.
//
//   Channel   Direction  Carries
//   req_      in         tuser: command; tdata: value
//   rsp_      out        tdata: popped_value, status, is_empty, is_full
//
// For each command, the transfer cycle updates the indices and accesses the RAM,
// and the result register is then loaded from the RAM read port once it is empty
// or being read. A new command is taken while a result still waits.
// Reset clears the indices, the count and both valid flags; the RAM is not cleared.
// A stalled result holds the following command in its pending stage.
module circular_deque_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] popped_value, [33:32] status,
                                    // [34] is_empty, [35] is_full, [39:36] zero
);
   import cdq_pkg::*;

   logic          req_xfer, load_rsp;
   mem_req_type   mem_req;
   rsp_info_type  info, pend_ff;
   logic          pend_valid_ff;
   logic          rsp_valid_ff;
   logic [39:0]   rsp_data_ff;
   logic [VAL_W-1:0] rd_data, popped;

   assign req_tready = !pend_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign load_rsp   = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   cdq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_xfer),
      .command (cmd_type'(req_tuser)),
      .value   (req_tdata),
      .mem_req (mem_req),
      .info    (info)
   );

   cdq_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (VAL_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (pend_ff.pop_ok) begin
         popped = rd_data;
      end else if (pend_ff.status == ST_EMPTY) begin
         popped = '1;
      end else begin
         popped = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            pend_valid_ff <= 1'b1;
         end else if (load_rsp) begin
            pend_valid_ff <= 1'b0;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pend_ff <= info;
      end
      if (load_rsp) begin
         rsp_data_ff <= {4'b0000, pend_ff.is_full, pend_ff.is_empty,
                         pend_ff.status, popped};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/cdq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the circular deque core and the bind that attaches them.
// Depends on cdq_pkg and circular_deque_core.
module cdq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import cdq_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[34] && rsp_tdata[35]))
      else $error("empty and full both set");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33:32] == ST_EMPTY)
         |-> (rsp_tdata[31:0] == 32'hFFFF_FFFF) && rsp_tdata[34])
      else $error("refused pop with wrong value or flags");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33:32] == ST_FULL)
         |-> (rsp_tdata[31:0] == 32'h0) && rsp_tdata[35])
      else $error("refused push with wrong value or flags");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);
